### design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants, status codes, the front-to-back token and the CRC-8 step
// used by the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

   localparam logic [2:0] ST_BUSY   = 3'd0;
   localparam logic [2:0] ST_GOOD   = 3'd1;
   localparam logic [2:0] ST_BADSIG = 3'd2;
   localparam logic [2:0] ST_LONG   = 3'd3;
   localparam logic [2:0] ST_CRC    = 3'd4;

   localparam logic [1:0] REG_SIG_FIRST  = 2'd0;
   localparam logic [1:0] REG_SIG_SECOND = 2'd1;
   localparam logic [1:0] REG_MAX_LEN    = 2'd2;

   // one classified byte on its way from the parser to the checker
   typedef struct packed {
      logic [7:0] data;
      logic       is_payload;
      logic       frame_end;
      logic [2:0] status;
      logic       crc_check;
      logic       crc_clear;
      logic [7:0] expected;
      logic [7:0] frame_length;
   } cfr_token_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### design/cfr_front.sv
// ----------------------------------------------------------------------------
// cfr_front
// Header parser: tracks the frame phase, holds the configuration registers,
// checks signature and length, and tags every byte for the checker.
// ----------------------------------------------------------------------------
module cfr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // rx_byte [7:0]
   input  logic                   req_tuser,   // restart [0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data,
   output logic                   tok_valid,
   input  logic                   tok_ready,
   output cfr_pkg::cfr_token_type tok
);
   import cfr_pkg::*;

   localparam logic [2:0] PH_SIG0    = 3'd0;
   localparam logic [2:0] PH_SIG1    = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_CRC     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'(HEADER_BYTES);

   logic [2:0] phase_ff, phase_in, phase_cur;
   logic       sig_bad_ff, sig_bad_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] expected_ff, expected_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] sig_first_ff, sig_second_ff, max_len_ff;
   logic       beat;

   assign req_tready = tok_ready;
   assign tok_valid  = req_tvalid;
   assign beat       = req_tvalid && tok_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      phase_cur   = (req_tuser || phase_ff > PH_PAYLOAD) ? PH_SIG0 : phase_ff;
      phase_in    = phase_cur;
      sig_bad_in  = sig_bad_ff;
      length_in   = length_ff;
      expected_in = expected_ff;
      left_in     = left_ff;

      tok.data         = req_tdata;
      tok.is_payload   = 1'b0;
      tok.frame_end    = 1'b0;
      tok.status       = ST_BUSY;
      tok.crc_check    = 1'b0;
      tok.crc_clear    = 1'b0;
      tok.expected     = expected_ff;
      tok.frame_length = length_ff;

      unique case (phase_cur)
         PH_SIG0: begin
            sig_bad_in       = (req_tdata != sig_first_ff);
            length_in        = 8'd0;
            expected_in      = 8'd0;
            left_in          = 8'd0;
            phase_in         = PH_SIG1;
            tok.crc_clear    = 1'b1;
            tok.frame_length = 8'd0;
         end
         PH_SIG1: begin
            if (req_tdata != sig_second_ff) begin
               sig_bad_in = 1'b1;
            end
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            length_in        = req_tdata;
            left_in          = req_tdata;
            tok.frame_length = req_tdata;
            phase_in         = PH_CRC;
         end
         PH_CRC: begin
            expected_in  = req_tdata;
            tok.expected = req_tdata;
            if (sig_bad_ff) begin
               tok.frame_end = 1'b1;
               tok.status    = ST_BADSIG;
               phase_in      = PH_SIG0;
            end else if (length_ff > max_len_ff) begin
               tok.frame_end = 1'b1;
               tok.status    = ST_LONG;
               phase_in      = PH_SIG0;
            end else if (length_ff == 8'd0) begin
               tok.frame_end = 1'b1;
               tok.crc_check = 1'b1;
               phase_in      = PH_SIG0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            tok.is_payload = 1'b1;
            left_in        = left_ff - 8'd1;
            if (left_in == 8'd0) begin
               tok.frame_end = 1'b1;
               tok.crc_check = 1'b1;
               phase_in      = PH_SIG0;
            end
         end
         default: begin
            phase_in = PH_SIG0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SIG0;
         sig_bad_ff  <= 1'b0;
         length_ff   <= 8'd0;
         expected_ff <= 8'd0;
         left_ff     <= 8'd0;
      end else if (beat) begin
         phase_ff    <= phase_in;
         sig_bad_ff  <= sig_bad_in;
         length_ff   <= length_in;
         expected_ff <= expected_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_first_ff  <= 8'd0;
         sig_second_ff <= 8'd0;
         max_len_ff    <= MAX_PAYLOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SIG_FIRST:  sig_first_ff  <= csr_data;
            REG_SIG_SECOND: sig_second_ff <= csr_data;
            REG_MAX_LEN:    max_len_ff    <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

### design/cfr_queue.sv
// ----------------------------------------------------------------------------
// cfr_queue
// Two-entry token queue between the parser and the checker.
// ----------------------------------------------------------------------------
module cfr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  cfr_pkg::cfr_token_type push_tok,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output cfr_pkg::cfr_token_type pop_tok
);
   import cfr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfr_token_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");
`endif

endmodule

### design/cfr_back.sv
// ----------------------------------------------------------------------------
// cfr_back
// Checker: runs the payload CRC, settles the frame status and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module cfr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tok_valid,
   output logic                   tok_ready,
   input  cfr_pkg::cfr_token_type tok,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // payload_byte [7:0], frame_length [15:8]
   output logic [3:0]             rsp_tuser,   // payload_valid [0], status [3:1]
   output logic                   rsp_tlast    // frame_end
);
   import cfr_pkg::*;

   logic       out_valid_ff;
   logic [7:0] crc_ff, crc_in, crc_next;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] flen_ff;
   logic       pvalid_ff;
   logic       fend_ff;
   logic [2:0] status_ff, status_in;
   logic       take;

   assign tok_ready = !out_valid_ff || rsp_tready;
   assign take      = tok_valid && tok_ready;

   always_comb begin
      crc_next  = tok.is_payload ? crc8_byte(crc_ff, tok.data) : crc_ff;
      crc_in    = tok.crc_clear ? CRC_INIT : crc_next;
      byte_in   = tok.is_payload ? tok.data : 8'd0;
      status_in = tok.status;
      if (tok.crc_check) begin
         status_in = (crc_next == tok.expected) ? ST_GOOD : ST_CRC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
      end else begin
         if (take) begin
            out_valid_ff <= 1'b1;
            crc_ff       <= crc_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= byte_in;
         flen_ff   <= tok.frame_length;
         pvalid_ff <= tok.is_payload;
         fend_ff   <= tok.frame_end;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {flen_ff, byte_ff};
   assign rsp_tuser  = {status_ff, pvalid_ff};
   assign rsp_tlast  = fend_ff;

`ifndef SYNTHESIS
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> status_ff == ST_BUSY)
      else $error("status set on a beat that does not end the frame");
   a_byte_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !pvalid_ff) |-> byte_ff == 8'd0)
      else $error("payload byte not cleared on a header beat");
   a_crc_cleared: assert property (@(posedge clock) disable iff (reset)
      (take && tok.crc_clear) |=> crc_ff == CRC_INIT)
      else $error("crc not reloaded at frame start");
`endif

endmodule

### design/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// CRC-8 framed packet receiver: parses a four-byte header, passes the payload
// through and reports one status per frame.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_      in    req_tvalid/tready      tdata rx_byte, tuser restart
//  rsp_      out   rsp_tvalid/tready      tdata payload_byte+frame_length,
//                                         tuser payload_valid+status, tlast
//  csr_      in    csr_valid/ready        csr_index, csr_data
//
//  one result beat per request beat, one per cycle while rsp_tready is high;
//  each byte passes the parser, then the queue, then the checker register.
//  the CRC-8 update is an eight-step unrolled step inside the checker.
//  synchronous reset clears the parse phase, the CRC and all valid flags.
//  the two-entry queue lets the parser keep taking bytes while the result
//  register waits on rsp_tready.
// ----------------------------------------------------------------------------
module crc8_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte [7:0]
   input  logic        req_tuser,   // restart [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_byte [7:0], frame_length [15:8]
   output logic [3:0]  rsp_tuser,   // payload_valid [0], status [3:1]
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import cfr_pkg::*;

   cfr_token_type front_tok, back_tok;
   logic          front_valid, front_ready;
   logic          back_valid, back_ready;

   cfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .tok_valid  (front_valid),
      .tok_ready  (front_ready),
      .tok        (front_tok)
   );

   cfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_tok   (front_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_tok    (back_tok)
   );

   cfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (back_valid),
      .tok_ready  (back_ready),
      .tok        (back_tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/sv/crc8_frame_receiver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_checker
// Watches the request, result and register channels of the frame receiver.
// It runs its own copy of the header parser and the CRC-8 check for every
// accepted request beat, then compares each result beat field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte [7:0]
   input  logic        req_tuser,   // restart [0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // payload_byte [7:0], frame_length [15:8]
   input  logic [3:0]  rsp_tuser,   // payload_valid [0], status [3:1]
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          frames_good,
   output int          frames_faulty
);
   import cfr_pkg::*;

   typedef enum logic [2:0] {
      SEEK_SIG_A, SEEK_SIG_B, SEEK_LENGTH, SEEK_CRC, IN_PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       frame_end;
      logic [2:0] status;
      logic [7:0] frame_length;
   } rx_result_type;

   logic [7:0]      sig_first_q;
   logic [7:0]      sig_second_q;
   logic [7:0]      max_len_q;
   parse_phase_type phase;
   logic            sig_bad;
   logic [7:0]      frame_len;
   logic [7:0]      crc_want;
   logic [7:0]      crc_run;
   logic [7:0]      bytes_left;
   rx_result_type   expected_results[$];
   int              fault_total  = 0;
   int              good_total   = 0;
   int              faulty_total = 0;

   // bit-serial form, msb first, no final xor
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic int field_ok(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         return 0;
      end
      return 1;
   endfunction

   task automatic predict_beat(input logic [7:0] rx, input logic restart,
                               output rx_result_type r);
      r = '0;
      if (restart) phase = SEEK_SIG_A;
      case (phase)
         SEEK_SIG_A: begin
            sig_bad    = (rx != sig_first_q);
            frame_len  = 8'h00;
            crc_want   = 8'h00;
            crc_run    = CRC_INIT;
            bytes_left = 8'h00;
            phase      = SEEK_SIG_B;
         end
         SEEK_SIG_B: begin
            if (rx != sig_second_q) sig_bad = 1'b1;
            phase = SEEK_LENGTH;
         end
         SEEK_LENGTH: begin
            frame_len      = rx;
            bytes_left     = rx;
            r.frame_length = rx;
            phase          = SEEK_CRC;
         end
         SEEK_CRC: begin
            crc_want       = rx;
            r.frame_length = frame_len;
            phase          = SEEK_SIG_A;
            r.frame_end    = 1'b1;
            if (sig_bad) begin
               r.status = ST_BADSIG;
            end else if (frame_len > max_len_q) begin
               r.status = ST_LONG;
            end else if (frame_len == 8'h00) begin
               r.status = (crc_run == crc_want) ? ST_GOOD : ST_CRC;
            end else begin
               r.frame_end = 1'b0;
               phase       = IN_PAYLOAD;
            end
         end
         default: begin
            r.payload_byte  = rx;
            r.payload_valid = 1'b1;
            r.frame_length  = frame_len;
            crc_run         = crc8_next(crc_run, rx);
            bytes_left      = bytes_left - 8'd1;
            if (bytes_left == 8'h00) begin
               r.frame_end = 1'b1;
               r.status    = (crc_run == crc_want) ? ST_GOOD : ST_CRC;
               phase       = SEEK_SIG_A;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rx_result_type want;
      rx_result_type got;
      rx_result_type next_res;
      if (reset) begin
         sig_first_q  = 8'h00;
         sig_second_q = 8'h00;
         max_len_q    = MAX_PAYLOAD_RESET;
         phase        = SEEK_SIG_A;
         sig_bad      = 1'b0;
         frame_len    = 8'h00;
         crc_want     = 8'h00;
         crc_run      = CRC_INIT;
         bytes_left   = 8'h00;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.payload_byte  = rsp_tdata[7:0];
            got.frame_length  = rsp_tdata[15:8];
            got.payload_valid = rsp_tuser[0];
            got.status        = rsp_tuser[3:1];
            got.frame_end     = rsp_tlast;
            if (expected_results.size() == 0) begin
               $error("result beat with no request beat waiting");
               fault_total++;
            end else begin
               want = expected_results.pop_front();
               if (!(field_ok("payload_byte", want.payload_byte, got.payload_byte) &
                     field_ok("payload_valid", want.payload_valid, got.payload_valid) &
                     field_ok("frame_end", want.frame_end, got.frame_end) &
                     field_ok("status", want.status, got.status) &
                     field_ok("frame_length", want.frame_length, got.frame_length)))
                  fault_total++;
               if (want.frame_end) begin
                  if (want.status == ST_GOOD) good_total++;
                  else faulty_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SIG_FIRST:  sig_first_q  = csr_data;
               REG_SIG_SECOND: sig_second_q = csr_data;
               REG_MAX_LEN:    max_len_q    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_beat(req_tdata, req_tuser, next_res);
            expected_results.push_back(next_res);
         end
      end
      mismatches    <= fault_total;
      outstanding   <= expected_results.size();
      frames_good   <= good_total;
      frames_faulty <= faulty_total;
   end

endmodule

### tb/sv/crc8_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_test
// Drives framed byte streams into the frame receiver under several signature
// and length-limit settings: good frames, empty payloads, bad CRCs, bad
// signatures, over-long lengths, frames cut short by a restart and line
// noise, with random idle bursts on both channels. A separate checker
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_test;
   import cfr_pkg::*;

   localparam logic [1:0] REG_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   logic        clock      = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte [7:0]
   logic        req_tuser;   // restart [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // payload_byte [7:0], frame_length [15:8]
   logic [3:0]  rsp_tuser;   // payload_valid [0], status [3:1]
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   int mismatches;
   int outstanding;
   int frames_good;
   int frames_faulty;
   int cycle_count = 0;
   int stall_left  = 0;
   int sent_bytes  = 0;
   int phase_bytes = 0;
   bit no_idle     = 1'b0;
   bit after_abort = 1'b0;

   crc8_frame_receiver DUT (.*);

   crc8_frame_receiver_checker checker_inst (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] value, input logic restart);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
      phase_bytes++;
   endtask

   // cut < 0 sends the whole frame, otherwise only the first cut bytes
   task automatic send_frame(input logic [7:0] sig_a, input logic [7:0] sig_b, input int len,
                             input bit corrupt, input bit restart, input int cut);
      logic [7:0] body[$];
      logic [7:0] hdr[4];
      logic [7:0] crc;
      int         total;
      crc = CRC_INIT;
      for (int i = 0; i < len; i++) begin
         body.push_back(pick_byte());
         crc = crc8_byte(crc, body[i]);
      end
      if (corrupt) crc ^= 8'($urandom_range(1, 255));
      hdr   = '{sig_a, sig_b, 8'(len), crc};
      total = (cut >= 0) ? cut : 4 + len;
      for (int i = 0; i < total; i++)
         send_beat(i < 4 ? hdr[i] : body[i - 4], i == 0 ? restart : 1'b0);
   endtask

   task automatic random_frames(input logic [7:0] sig_a, input logic [7:0] sig_b,
                                input int max_len, input int target);
      int         pick;
      int         len;
      int         flip;
      bit         rs;
      logic [7:0] a;
      logic [7:0] b;
      phase_bytes = 0;
      while (phase_bytes < target) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 40);
         if (len > max_len) len = $urandom_range(0, max_len);
         rs          = after_abort || ($urandom_range(0, 7) == 0);
         after_abort = 1'b0;
         if (pick < 60) begin
            send_frame(sig_a, sig_b, len, 1'b0, rs, -1);
         end else if (pick < 72) begin
            send_frame(sig_a, sig_b, len, 1'b1, rs, -1);
         end else if (pick < 80) begin
            flip = $urandom_range(1, 3);
            a    = flip[0] ? sig_a ^ 8'($urandom_range(1, 255)) : sig_a;
            b    = flip[1] ? sig_b ^ 8'($urandom_range(1, 255)) : sig_b;
            send_frame(a, b, $urandom_range(0, 255), $urandom_range(0, 1), rs, 4);
         end else if (pick < 86) begin
            if (max_len < 255)
               send_frame(sig_a, sig_b, $urandom_range(max_len + 1, 255),
                          $urandom_range(0, 1), rs, 4);
            else
               send_frame(sig_a, sig_b, len, 1'b0, rs, -1);
         end else if (pick < 93) begin
            send_frame(sig_a, sig_b, len, 1'b0, rs, $urandom_range(1, 3 + len));
            after_abort = 1'b1;
         end else begin
            repeat ($urandom_range(1, 6))
               send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1));
            after_abort = 1'b1;
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller lowers it after the last write
   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] sig_a, input logic [7:0] sig_b,
                                 input logic [7:0] max_len, input bit poke_unused);
      drain();
      write_reg(REG_SIG_FIRST, sig_a);
      write_reg(REG_SIG_SECOND, sig_b);
      write_reg(REG_MAX_LEN, max_len);
      if (poke_unused) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] rand_a;
      logic [7:0] rand_b;
      logic [7:0] rand_max;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_SIG_FIRST;
      csr_data   <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apply_settings(8'hA5, 8'h5A, 8'hFF, 1'b1);
      send_frame(8'hA5, 8'h5A, 2, 1'b0, 1'b0, -1);
      // empty payload, header crc matches and then does not
      send_frame(8'hA5, 8'h5A, 0, 1'b0, 1'b1, -1);
      send_frame(8'hA5, 8'h5A, 0, 1'b1, 1'b0, -1);
      send_frame(8'hA5, 8'h5A, 1, 1'b1, 1'b0, -1);
      send_frame(8'hA5, 8'h55, 0, 1'b0, 1'b0, -1);
      send_frame(8'hA5, 8'h5A, 255, 1'b0, 1'b1, -1);
      random_frames(8'hA5, 8'h5A, 255, 70);

      apply_settings(8'h00, 8'h00, 8'h00, 1'b0);
      // bad signature wins over a too-long length
      send_frame(8'h01, 8'h00, 5, 1'b0, 1'b1, 4);
      send_frame(8'h00, 8'h00, 9, 1'b0, 1'b0, 4);
      random_frames(8'h00, 8'h00, 0, 55);

      apply_settings(8'hFF, 8'hFF, 8'd16, 1'b1);
      random_frames(8'hFF, 8'hFF, 16, 70);

      rand_a   = 8'($urandom_range(0, 255));
      rand_b   = 8'($urandom_range(0, 255));
      rand_max = 8'($urandom_range(4, 60));
      apply_settings(rand_a, rand_b, rand_max, 1'b1);
      random_frames(rand_a, rand_b, rand_max, 70);

      no_idle <= 1'b1;
      apply_settings(8'h3C, 8'hC3, 8'hFF, 1'b0);
      random_frames(8'h3C, 8'hC3, 255, 65);
      drain();

      $display("sent %0d request bytes under five register settings", sent_bytes);
      $display("frames closed: %0d good, %0d with an error status",
               frames_good, frames_faulty);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
